// File: rtl/core/gmab_pkg.sv
// ----------------------------------------------------------------------------
// Gated moving-average bands package
// Shared constants, register indexes and types for the band averaging block.
// ----------------------------------------------------------------------------
package gmab_pkg;

  localparam int BAND_DEPTH_DEF  = 64;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int NUM_BANDS  = 4;
  localparam int WIN_W      = 7;
  localparam int THR_W      = 11;
  localparam int MODE_W     = 2;
  localparam int DET_W      = 12;
  localparam int SUM_W      = 16;
  localparam int AVG_W      = 10;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [AVG_W-1:0] AVG_MAX = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd5;

  localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAIR  = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PUSH, ST_DIV, ST_OUT
  } state_t;

  // Per-channel result of the detection lanes.
  typedef struct packed {
    logic [DET_W-1:0] det;
    logic             hit;
  } lane_res_t;

endpackage

// File: rtl/core/gmab_lane.sv
// ----------------------------------------------------------------------------
// Detection lane
// Holds three past samples of one channel and forms the four-tap difference
// and its threshold compare.
// ----------------------------------------------------------------------------
module gmab_lane #(
  parameter int SAMPLE_BITS = gmab_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [gmab_pkg::THR_W-1:0]   threshold,
  output gmab_pkg::lane_res_t          res
);
  localparam int DW = SAMPLE_BITS + 3;

  logic [SAMPLE_BITS-1:0] h0_r, h1_r, h2_r;
  logic signed [DW-1:0]   d;
  logic [DW-1:0]          mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h0_r <= '0;
      h1_r <= '0;
      h2_r <= '0;
    end else if (shift) begin
      h2_r <= h1_r;
      h1_r <= h0_r;
      h0_r <= sample;
    end
  end

  always_comb begin
    d = $signed({3'b000, sample}) - $signed({3'b000, h0_r})
      + $signed({3'b000, h1_r}) - $signed({3'b000, h2_r});
    mag = d[DW-1] ? DW'(-d) : DW'(d);
    res.det = gmab_pkg::DET_W'(d);
    res.hit = mag > DW'(threshold);
  end

endmodule

// File: rtl/core/gmab_divider.sv
// ----------------------------------------------------------------------------
// Band mean divider
// Restoring divider, one quotient bit per cycle, with saturation at the top.
// ----------------------------------------------------------------------------
module gmab_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gmab_pkg::SUM_W-1:0]   dividend,
  input  logic [gmab_pkg::WIN_W-1:0]   divisor,
  output logic                         done,
  output logic [gmab_pkg::AVG_W-1:0]   quotient
);
  localparam int SW = gmab_pkg::SUM_W;

  logic [SW-1:0]        q_r;
  logic [gmab_pkg::WIN_W:0] rem_r;
  logic [gmab_pkg::WIN_W-1:0] den_r;
  logic [4:0]           cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [gmab_pkg::WIN_W:0] trial;

  assign trial = {rem_r[gmab_pkg::WIN_W-1:0], q_r[SW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      // The quotient is complete in the cycle after the last iteration, as done rises.
      done_r <= busy_r && !start && (cnt_r == 5'd1);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(SW);
        q_r    <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= trial - {1'b0, den_r};
          q_r   <= {q_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[SW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) busy_r <= 1'b0;
      end
    end
  end

  assign done     = done_r;
  assign quotient = (q_r > SW'(gmab_pkg::AVG_MAX)) ? gmab_pkg::AVG_MAX
                                                   : q_r[gmab_pkg::AVG_W-1:0];

endmodule

// File: rtl/core/gated_moving_average_bands.sv
// Per request, each channel gets a decision step; a hit channel then gets a read
// and a write step for every band it feeds. Four serial divisions follow, one
// per band. One item at a time: a new request is taken only after the result
// has been accepted. Pushes and the serial divider set the time per item.
// Reset is synchronous; after reset a clearing pass over all 4*BAND_DEPTH entries
// (depth rounded up to a power of two) zeroes the band store first.
// ----------------------------------------------------------------------------
// Gated moving-average bands, top level
// Four detection lanes, a sequential band updater and a serial mean divider.
// ----------------------------------------------------------------------------
module gated_moving_average_bands #(
  parameter int BAND_DEPTH  = gmab_pkg::BAND_DEPTH_DEF,
  parameter int SAMPLE_BITS = gmab_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_ch0, sample_ch1, sample_ch2, sample_ch3 from the lowest bit up
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // average_band0..3, detect_ch0..3, active_group_a, active_group_b,
  // last_channel_a, last_channel_b from the lowest bit up
  output logic [95:0]                       out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gmab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmab_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int PW = $clog2(BAND_DEPTH);
  localparam int AW = PW + 2;
  localparam int SW = gmab_pkg::SUM_W;

  gmab_pkg::state_t state_r, state_nxt;

  logic [gmab_pkg::WIN_W-1:0]  win_r [4];
  logic [gmab_pkg::THR_W-1:0]  thr_r;
  logic [gmab_pkg::MODE_W-1:0] mode_r;

  logic [SAMPLE_BITS-1:0] store [2**AW];
  logic [SAMPLE_BITS-1:0] rd_r;
  logic [SW-1:0]          sum_r [4];
  logic [PW-1:0]          ptr_r [4];
  logic [1:0]             glast_r [2];

  logic [SAMPLE_BITS-1:0]  smp_r [4];
  gmab_pkg::lane_res_t     lres [4];
  logic [gmab_pkg::DET_W-1:0] det_r [4];
  logic [1:0]              act_r;
  logic [gmab_pkg::AVG_W-1:0] avg_r [4];

  logic [AW-1:0] clr_r;
  logic [1:0]    ch_r, band_r;
  logic          phase_r;
  logic          lane_shift;
  logic          hist_shift;
  logic          div_start, div_done;
  logic [gmab_pkg::AVG_W-1:0] div_q;
  logic          div_go_r;

  function automatic logic [gmab_pkg::WIN_W-1:0] eff_win(
    input logic [gmab_pkg::WIN_W-1:0] w);
    if (w == '0) return gmab_pkg::WIN_W'(1);
    if (32'(w) > BAND_DEPTH) return gmab_pkg::WIN_W'(BAND_DEPTH);
    return w;
  endfunction

  // Band range fed by a channel: lo/hi band and group.
  logic [1:0] lo_b, hi_b;
  logic       grp;
  always_comb begin
    if (mode_r == gmab_pkg::MODE_SPLIT) begin
      grp  = ch_r[0];
      lo_b = ch_r[0] ? 2'd2 : 2'd0;
      hi_b = ch_r[0] ? 2'd3 : 2'd1;
    end else if (mode_r == gmab_pkg::MODE_PAIR) begin
      grp = 1'b0; lo_b = 2'd0; hi_b = 2'd1;
    end else begin
      grp = 1'b0; lo_b = 2'd0; hi_b = 2'd3;
    end
  end

  logic [gmab_pkg::WIN_W-1:0] cur_w;
  logic [PW-1:0] p_eff, p_inc;
  logic [AW-1:0] addr;
  assign cur_w = eff_win(win_r[band_r]);
  assign p_eff = (gmab_pkg::WIN_W'(ptr_r[band_r]) >= cur_w) ? '0 : ptr_r[band_r];
  assign p_inc = (gmab_pkg::WIN_W'(p_eff) + 1'b1 >= cur_w) ? '0 : PW'(p_eff + 1'b1);
  assign addr  = {band_r, p_eff};

  // Every lane shifts its history once, after the last channel is done.
  assign hist_shift = lane_shift && (ch_r == 2'd3);

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      gmab_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
        .clk(clk), .rst_n(rst_n), .shift(hist_shift),
        .sample(smp_r[g]), .threshold(thr_r), .res(lres[g]));
    end
  endgenerate

  gmab_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(sum_r[band_r]), .divisor(eff_win(win_r[band_r])),
    .done(div_done), .quotient(div_q));

  assign in_tready  = (state_r == gmab_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (state_r == gmab_pkg::ST_OUT);
  assign div_start  = div_go_r;

  always_comb begin
    state_nxt  = state_r;
    lane_shift = 1'b0;
    unique case (state_r)
      gmab_pkg::ST_CLEAR: if (clr_r == '1) state_nxt = gmab_pkg::ST_IDLE;
      gmab_pkg::ST_IDLE:  if (in_tvalid) state_nxt = gmab_pkg::ST_PUSH;
      gmab_pkg::ST_PUSH:
        if (phase_r ? (clr_r[0] && band_r == hi_b) : !lres[ch_r].hit) begin
          lane_shift = 1'b1;
          if (ch_r == 2'd3) state_nxt = gmab_pkg::ST_DIV;
        end
      gmab_pkg::ST_DIV:
        if (div_done && band_r == 2'd3) state_nxt = gmab_pkg::ST_OUT;
      gmab_pkg::ST_OUT:   if (out_tready) state_nxt = gmab_pkg::ST_IDLE;
      default:            state_nxt = gmab_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmab_pkg::ST_CLEAR;
      clr_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        win_r[i] <= gmab_pkg::WIN_W'(1);
        sum_r[i] <= '0;
        ptr_r[i] <= '0;
      end
      thr_r      <= gmab_pkg::THR_W'(64);
      mode_r     <= '0;
      glast_r[0] <= '0;
      glast_r[1] <= '0;
      ch_r <= '0; band_r <= '0; phase_r <= 1'b0; div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == gmab_pkg::ST_PUSH && state_nxt == gmab_pkg::ST_DIV) ||
                  (state_r == gmab_pkg::ST_DIV && div_done && band_r != 2'd3);
      if (cfg_valid) begin
        case (cfg_index)
          gmab_pkg::REG_WINDOW_A:  win_r[0] <= cfg_data[gmab_pkg::WIN_W-1:0];
          gmab_pkg::REG_WINDOW_B:  win_r[1] <= cfg_data[gmab_pkg::WIN_W-1:0];
          gmab_pkg::REG_WINDOW_C:  win_r[2] <= cfg_data[gmab_pkg::WIN_W-1:0];
          gmab_pkg::REG_WINDOW_D:  win_r[3] <= cfg_data[gmab_pkg::WIN_W-1:0];
          gmab_pkg::REG_THRESHOLD: thr_r <= cfg_data;
          gmab_pkg::REG_MODE:      mode_r <= cfg_data[gmab_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        gmab_pkg::ST_CLEAR: clr_r <= clr_r + 1'b1;
        gmab_pkg::ST_IDLE:
          if (in_tvalid) begin
            for (int i = 0; i < 4; i++)
              smp_r[i] <= in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
            ch_r <= '0; phase_r <= 1'b0; act_r <= '0; band_r <= '0;
          end
        gmab_pkg::ST_PUSH: begin
          if (!phase_r) begin
            det_r[ch_r] <= lres[ch_r].det;
            if (lres[ch_r].hit) begin
              act_r[grp]   <= 1'b1;
              glast_r[grp] <= ch_r;
              phase_r      <= 1'b1;
              band_r       <= lo_b;
            end
          end else if (!clr_r[0]) begin
            // Read cycle: rd_r loads the entry about to be replaced.
            clr_r[0] <= 1'b1;
          end else begin
            clr_r[0] <= 1'b0;
            sum_r[band_r] <= sum_r[band_r] - SW'(rd_r) + SW'(smp_r[ch_r]);
            ptr_r[band_r] <= p_inc;
            if (band_r == hi_b) phase_r <= 1'b0;
            else band_r <= band_r + 1'b1;
          end
          if (state_nxt == gmab_pkg::ST_DIV) band_r <= '0;
          if (lane_shift) ch_r <= ch_r + 1'b1;
        end
        gmab_pkg::ST_DIV:
          if (div_done) begin
            avg_r[band_r] <= div_q;
            if (band_r != 2'd3) band_r <= band_r + 1'b1;
          end
        gmab_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // The stall decision: hit channel stays in PUSH through read/write pairs.
  // clr_r[0] doubles as the read/write phase toggle once clearing is done;
  // the clear counter wraps to zero as clearing ends, so every pair starts
  // on its read cycle and leaves the bit at zero again.

  always_ff @(posedge clk) begin
    if (state_r == gmab_pkg::ST_CLEAR) begin
      store[clr_r] <= '0;
    end else if (state_r == gmab_pkg::ST_PUSH && phase_r && clr_r[0]) begin
      store[addr] <= smp_r[ch_r];
    end
    rd_r <= store[addr];
  end

  assign out_tdata = {2'b00, glast_r[1], glast_r[0], act_r[1], act_r[0],
                      det_r[3], det_r[2], det_r[1], det_r[0],
                      avg_r[3], avg_r[2], avg_r[1], avg_r[0]};

endmodule

// File: rtl/core/gmab_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level handshakes of the band averaging block.
// ----------------------------------------------------------------------------
module gmab_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [95:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while a result waits");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken at once");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid)
    else $error("result without work");
endmodule

bind gated_moving_average_bands gmab_checker u_gmab_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
